// ===== sv/ppe_pkg.sv =====
package ppe_pkg;

    // Pool geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REPORT = (SLOTS < 16) ? SLOTS : 16;

    // Port widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Function codes (tuser of the input side)
    localparam logic [FUNC_W-1:0] FUNC_SPAWN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

    localparam logic [14:0] WIDTH_RESET  = 15'd320;
    localparam logic [14:0] HEIGHT_RESET = 15'd240;

    // Generator
    localparam logic [30:0] LCG_MUL    = 31'd1103515245;
    localparam logic [30:0] LCG_INC    = 31'd12345;
    localparam logic [30:0] SEED_RESET = 31'd9999;

    // Kind codes
    localparam logic [2:0] KIND_SPARK    = 3'd0;
    localparam logic [2:0] KIND_HEART    = 3'd1;
    localparam logic [2:0] KIND_STAR     = 3'd2;
    localparam logic [2:0] KIND_CONFETTI = 3'd3;
    localparam logic [2:0] KIND_SLEEP    = 3'd4;
    localparam logic [2:0] KIND_SIGNAL   = 3'd5;

    typedef struct packed {
        logic latch;
        logic find;
        logic lcg_step;
        logic mod_step;
        logic spawn_write;
        logic load_reject;
        logic tick_slot;
        logic clear_pool;
    } ppe_cmd_t;

    typedef struct packed {
        logic free_found;
        logic has_draw;
        logic mod_last;
        logic last_draw;
        logic out_free;
        logic tick_out;
        logic tick_last;
    } ppe_status_t;

    typedef struct packed {
        logic [7:0] vx;
        logic [7:0] vy;
        logic [2:0] size;
        logic [4:0] life;
    } spawn_param_t;

    // Number of generator draws a spawn of this kind takes
    function automatic logic [1:0] draw_count(input logic [2:0] kind);
        logic [1:0] n;
        unique case (kind) inside
            KIND_SPARK:                     n = 2'd3;
            KIND_STAR, KIND_CONFETTI:       n = 2'd2;
            KIND_SLEEP:                     n = 2'd1;
            KIND_SIGNAL:                    n = 2'd2;
            default:                        n = 2'd0;
        endcase
        return n;
    endfunction

    // Span (hi - lo + 1) of draw number idx for this kind
    function automatic logic [3:0] draw_span(input logic [2:0] kind, input logic [1:0] idx);
        logic [3:0] m;
        m = 4'd1;
        unique case (kind) inside
            KIND_SPARK:
                case (idx)
                    2'd0:    m = 4'd5;
                    2'd1:    m = 4'd4;
                    default: m = 4'd11;
                endcase
            KIND_STAR, KIND_CONFETTI:
                m = (idx == 2'd0) ? 4'd9 : 4'd5;
            KIND_SLEEP:
                m = 4'd3;
            KIND_SIGNAL:
                m = (idx == 2'd0) ? 4'd5 : 4'd4;
            default:
                m = 4'd1;
        endcase
        return m;
    endfunction

    // Motion, size and life from kind and the raw remainders drawn
    function automatic spawn_param_t spawn_param(input logic [2:0] kind, input logic [3:0] d0,
                                                 input logic [3:0] d1, input logic [3:0] d2);
        spawn_param_t p;
        p = '0;
        unique case (kind) inside
            KIND_SPARK:
            begin
                p.vx   = {4'd0, d0} - 8'd2;
                p.vy   = 8'd0 - ({4'd0, d1} + 8'd1);
                p.size = 3'd2;
                p.life = 5'd10 + {1'b0, d2};
            end
            KIND_HEART:
            begin
                p.vx   = 8'd0;
                p.vy   = 8'hFE;
                p.size = 3'd4;
                p.life = 5'd25;
            end
            KIND_STAR, KIND_CONFETTI:
            begin
                p.vx   = {4'd0, d0} - 8'd4;
                p.vy   = 8'd0 - ({4'd0, d1} + 8'd2);
                p.size = 3'd3;
                p.life = 5'd30;
            end
            KIND_SLEEP:
            begin
                p.vx   = 8'd1;
                p.vy   = 8'hFF;
                p.size = 3'd2 + d0[2:0];
                p.life = 5'd30;
            end
            KIND_SIGNAL:
            begin
                p.vx   = {4'd0, d0} - 8'd2;
                p.vy   = 8'd0 - ({4'd0, d1} + 8'd2);
                p.size = 3'd2;
                p.life = 5'd15;
            end
            default:
            begin
                p.vx   = 8'd0;
                p.vy   = 8'd2;
                p.size = 3'd3;
                p.life = 5'd20;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== sv/particle_pool_engine.sv =====
// Spawn: latch, free-slot search, then per generator draw one multiply step and
// eight 4-bit remainder steps, then slot write with result word. Clear: latch, then
// pool clear with its word. Tick: one slot per cycle unless the result word stalls,
// over all slots, one word per reported slot. One item in work at a time;
// the next item is taken once the last word is registered, while it still waits on m_tready.
// Reset (rst_n, async low): pool empty, enabled 1, screen 320 x 240, seed 9999.
module particle_pool_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] spawn_x, [31:16] spawn_y, [34:32] spawn_kind, [50:35] spawn_color
    input  logic [ppe_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] func
    input  logic [ppe_pkg::FUNC_W-1:0]        s_tuser,
    // Result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] slot, [4] accepted, [5] live, [21:6] part_x, [37:22] part_y,
    // [40:38] part_kind, [56:41] part_color, [59:57] part_size
    output logic [ppe_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // Register writes: 0 enabled, 1 screen_width, 2 screen_height
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ppe_pkg::*;

    ppe_cmd_t    cmd;
    ppe_status_t status;

    // Sequencer: accept, free-slot search, draw loop, slot walk for tick
    ppe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Slot store, generator with remainder unit, aging logic, result register
    ppe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/ppe_ctrl.sv =====
module ppe_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic [ppe_pkg::FUNC_W-1:0]    func,
    output logic                          s_tready,
    input  ppe_pkg::ppe_status_t          status,
    output ppe_pkg::ppe_cmd_t             cmd
);
    import ppe_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_LCG    = 8'b0000_0100,
        S_MOD    = 8'b0000_1000,
        S_SPAWN  = 8'b0001_0000,
        S_REJECT = 8'b0010_0000,
        S_TICK   = 8'b0100_0000,
        S_CLEAR  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    unique case (func)
                        FUNC_SPAWN: state_next = S_FIND;
                        FUNC_TICK:  state_next = S_TICK;
                        FUNC_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
                if (!status.free_found)
                    state_next = S_REJECT;
                else if (status.has_draw)
                    state_next = S_LCG;
                else
                    state_next = S_SPAWN;
            end
            S_LCG:
            begin
                cmd.lcg_step = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                    state_next = status.last_draw ? S_SPAWN : S_LCG;
            end
            S_SPAWN:
            begin
                if (status.out_free)
                begin
                    cmd.spawn_write = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_REJECT:
            begin
                if (status.out_free)
                begin
                    cmd.load_reject = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (!status.tick_out || status.out_free)
                begin
                    cmd.tick_slot = 1'b1;
                    if (status.tick_last)
                        state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (status.out_free)
                begin
                    cmd.clear_pool = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/ppe_dp.sv =====
module ppe_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ppe_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppe_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  ppe_pkg::ppe_cmd_t                 cmd,
    output ppe_pkg::ppe_status_t              status
);
    import ppe_pkg::*;

    localparam logic [SLOT_W:0]   REPORT_C    = (SLOT_W+1)'(REPORT);
    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] REPORT_LAST = SLOT_W'(REPORT - 1);

    function automatic logic [OUT_DATA_W-1:0] pack_out(
        input logic [3:0] slot, input logic acc, input logic live,
        input logic [15:0] x, input logic [15:0] y, input logic [2:0] kind,
        input logic [15:0] color, input logic [2:0] size);
        return {4'd0, size, color, kind, y, x, live, acc, slot};
    endfunction

    // Configuration
    logic        enabled_reg;
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic        cfg_we;
    logic        disable_wr;

    // Slot storage
    logic [SLOTS-1:0] active_reg;
    logic [15:0]      x_mem     [SLOTS];
    logic [15:0]      y_mem     [SLOTS];
    logic [7:0]       vx_mem    [SLOTS];
    logic [7:0]       vy_mem    [SLOTS];
    logic [2:0]       kind_mem  [SLOTS];
    logic [15:0]      color_mem [SLOTS];
    logic [2:0]       size_mem  [SLOTS];
    logic [4:0]       life_mem  [SLOTS];

    // Latched request
    logic [15:0] in_x_reg;
    logic [15:0] in_y_reg;
    logic [2:0]  in_kind_reg;
    logic [15:0] in_color_reg;

    // Free slot search
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] free_idx_reg;

    // Generator and remainder unit
    logic [30:0] seed_reg;
    logic [3:0]  rem_reg;
    logic [3:0]  rem_next;
    logic [2:0]  step_reg;
    logic [1:0]  draw_idx_reg;
    logic [3:0]  draw_reg [3];
    logic [3:0]  span;
    logic [1:0]  n_draws;
    logic [31:0] seed_pad;
    logic [3:0]  nib;
    spawn_param_t sp;

    // Tick walk
    logic [SLOT_W-1:0] slot_idx_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic [15:0] rd_x_reg;
    logic [15:0] rd_y_reg;
    logic [7:0]  rd_vx_reg;
    logic [7:0]  rd_vy_reg;
    logic [2:0]  rd_kind_reg;
    logic [15:0] rd_color_reg;
    logic [2:0]  rd_size_reg;
    logic [4:0]  rd_life_reg;
    logic        rd_active;
    logic [15:0] new_x;
    logic [15:0] new_y;
    logic [7:0]  new_vy;
    logic        off_screen;
    logic        age_live;
    logic        do_age;
    logic [15:0] post_x;
    logic [15:0] post_y;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid;
    assign disable_wr = cfg_we && (cfg_index == CFG_ENABLED) && !cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED: enabled_reg <= cfg_data[0];
                CFG_WIDTH:   width_reg   <= cfg_data;
                CFG_HEIGHT:  height_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Remainder of the seed by the draw span, four bits per cycle, MSB first
    assign n_draws  = draw_count(in_kind_reg);
    assign span     = draw_span(in_kind_reg, draw_idx_reg);
    assign seed_pad = {1'b0, seed_reg};
    assign nib      = seed_pad[{~step_reg, 2'b00} +: 4];

    always_comb
    begin
        logic [4:0] r;
        r = {1'b0, rem_reg};
        for (int b = 3; b >= 0; b--)
        begin
            r = {r[3:0], nib[b]};
            if (r >= {1'b0, span})
                r = r - {1'b0, span};
        end
        rem_next = r[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= SEED_RESET;
            step_reg     <= '0;
            draw_idx_reg <= '0;
            slot_idx_reg <= '0;
        end
        else
        begin
            if (cmd.lcg_step)
            begin
                seed_reg <= 31'(seed_reg * LCG_MUL + LCG_INC);
                step_reg <= '0;
            end
            else if (cmd.mod_step)
                step_reg <= step_reg + 3'd1;

            if (cmd.latch)
                draw_idx_reg <= '0;
            else if (cmd.mod_step && status.mod_last)
                draw_idx_reg <= draw_idx_reg + 2'd1;

            if (cmd.latch)
                slot_idx_reg <= '0;
            else if (cmd.tick_slot)
                slot_idx_reg <= slot_idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_x_reg     <= s_tdata[15:0];
            in_y_reg     <= s_tdata[31:16];
            in_kind_reg  <= s_tdata[34:32];
            in_color_reg <= s_tdata[50:35];
        end
        if (cmd.find)
            free_idx_reg <= free_idx;
        if (cmd.lcg_step)
            rem_reg <= '0;
        else if (cmd.mod_step)
            rem_reg <= rem_next;
        if (cmd.mod_step && status.mod_last)
            draw_reg[draw_idx_reg] <= rem_next;
    end

    assign sp = spawn_param(in_kind_reg, draw_reg[0], draw_reg[1], draw_reg[2]);

    // Slot store read into registers at the walk pointer's next value; the slot being
    // written back is never the one read next
    assign rd_addr = cmd.latch ? '0
                   : (cmd.tick_slot ? slot_idx_reg + SLOT_W'(1) : slot_idx_reg);

    always_ff @(posedge clk)
    begin
        rd_x_reg     <= x_mem[rd_addr];
        rd_y_reg     <= y_mem[rd_addr];
        rd_vx_reg    <= vx_mem[rd_addr];
        rd_vy_reg    <= vy_mem[rd_addr];
        rd_kind_reg  <= kind_mem[rd_addr];
        rd_color_reg <= color_mem[rd_addr];
        rd_size_reg  <= size_mem[rd_addr];
        rd_life_reg  <= life_mem[rd_addr];
    end

    // Aging of the slot under the walk pointer
    assign rd_active = active_reg[slot_idx_reg];

    assign new_x  = rd_x_reg + {{8{rd_vx_reg[7]}}, rd_vx_reg};
    assign new_y  = rd_y_reg + {{8{rd_vy_reg[7]}}, rd_vy_reg};
    assign new_vy = (rd_kind_reg == KIND_CONFETTI) ? rd_vy_reg + 8'd1 : rd_vy_reg;
    assign off_screen = new_x[15] || (new_x[14:0] > width_reg)
                     || new_y[15] || (new_y[14:0] > height_reg);
    assign do_age   = enabled_reg && rd_active;
    assign age_live = do_age ? ((rd_life_reg != 5'd0) && !off_screen) : rd_active;
    assign post_x   = enabled_reg ? new_x : rd_x_reg;
    assign post_y   = enabled_reg ? new_y : rd_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (disable_wr || cmd.clear_pool)
            active_reg <= '0;
        else if (cmd.spawn_write)
            active_reg[free_idx_reg] <= 1'b1;
        else if (cmd.tick_slot && do_age)
            active_reg[slot_idx_reg] <= age_live;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.spawn_write)
        begin
            x_mem[free_idx_reg]     <= in_x_reg;
            y_mem[free_idx_reg]     <= in_y_reg;
            vx_mem[free_idx_reg]    <= sp.vx;
            vy_mem[free_idx_reg]    <= sp.vy;
            kind_mem[free_idx_reg]  <= in_kind_reg;
            color_mem[free_idx_reg] <= in_color_reg;
            size_mem[free_idx_reg]  <= sp.size;
            life_mem[free_idx_reg]  <= sp.life;
        end
        else if (cmd.tick_slot && do_age && (rd_life_reg != 5'd0))
        begin
            x_mem[slot_idx_reg]    <= new_x;
            y_mem[slot_idx_reg]    <= new_y;
            vy_mem[slot_idx_reg]   <= new_vy;
            life_mem[slot_idx_reg] <= rd_life_reg - 5'd1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.spawn_write || cmd.load_reject || cmd.clear_pool
                 || (cmd.tick_slot && status.tick_out))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.spawn_write)
        begin
            out_data_reg <= pack_out(4'(free_idx_reg), 1'b1, 1'b1, in_x_reg, in_y_reg,
                                     in_kind_reg, in_color_reg, sp.size);
            out_last_reg <= 1'b1;
        end
        else if (cmd.load_reject)
        begin
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.clear_pool)
        begin
            out_data_reg <= pack_out(4'd0, 1'b1, 1'b0, 16'd0, 16'd0, 3'd0, 16'd0, 3'd0);
            out_last_reg <= 1'b1;
        end
        else if (cmd.tick_slot && status.tick_out)
        begin
            if (age_live)
                out_data_reg <= pack_out(4'(slot_idx_reg), enabled_reg, 1'b1, post_x, post_y,
                                         rd_kind_reg, rd_color_reg, rd_size_reg);
            else
                out_data_reg <= pack_out(4'(slot_idx_reg), enabled_reg, 1'b0, 16'd0, 16'd0,
                                         3'd0, 16'd0, 3'd0);
            out_last_reg <= (slot_idx_reg == REPORT_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign status.free_found = free_any && enabled_reg;
    assign status.has_draw   = (n_draws != 2'd0);
    assign status.mod_last   = (step_reg == 3'd7);
    assign status.last_draw  = (draw_idx_reg == n_draws - 2'd1);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.tick_out   = ({1'b0, slot_idx_reg} < REPORT_C);
    assign status.tick_last  = (slot_idx_reg == SLOT_LAST);

endmodule

// ===== sv/ppe_checker.sv =====
module ppe_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [ppe_pkg::FUNC_W-1:0]        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ppe_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              m_tlast
);
    import ppe_pkg::*;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A word that is not accepted never shows a live slot
    a_rej_dead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> !m_tdata[5])
        else $error("live slot in a rejected or disabled word");

    // Idle slots report zero particle fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[5] |-> (m_tdata[59:6] == 54'd0))
        else $error("idle slot with particle fields");

    // A live particle always has a size
    a_live_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> (m_tdata[59:57] != 3'd0))
        else $error("live particle with zero size");

    // A real request holds off the next one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser == FUNC_SPAWN) || (s_tuser == FUNC_TICK)
        || (s_tuser == FUNC_CLEAR)) |=> !s_tready)
        else $error("input taken while a request is in work");

endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
